### sv/sisu_pkg.sv
package sisu_pkg;

  // default number of record cells
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int ID_W    = 31;
  localparam int PRICE_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;  // place the offered record into the chain
    logic emit;    // head item taken, shift the chain down
  } sisu_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_one;  // exactly one record left in the chain
  } sisu_stat_t;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } sisu_state_t;

endpackage

### sv/stable_insertion_sorter_unit.sv
// Stable insertion sorter. Records (id, price) are loaded one item per cycle
// into a chain of CAPACITY cells that all compare against the new price at
// once, so each record is placed as it is taken; records with a strictly
// greater price move up one cell, so equal prices keep arrival order. The
// record marked final_record is placed like the others, then the whole set
// streams out in ascending price order from the head cell, one result item per
// cycle when result_stall is low; item_stall stays high for the whole of
// that run, which holds at most CAPACITY records. end_of_run marks the last
// result, and overflowed is high on every result of a set that lost records
// arriving after the chain was full. After the run the next item opens a new set.
module stable_insertion_sorter_unit
  import sisu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [ID_W-1:0]    record_id,
  input  logic [PRICE_W-1:0] price_cents,
  input  logic               final_record,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [ID_W-1:0]    sorted_id,
  output logic [PRICE_W-1:0] sorted_price,
  output logic               end_of_run,
  output logic               overflowed
);

  sisu_cmd_t  cmd;
  sisu_stat_t stat;

  // sequencing
  sisu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .final_record (final_record),
    .result_stall (result_stall),
    .stat         (stat),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // record cells
  sisu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .record_id    (record_id),
    .price_cents  (price_cents),
    .stat         (stat),
    .sorted_id    (sorted_id),
    .sorted_price (sorted_price),
    .end_of_run   (end_of_run),
    .overflowed   (overflowed)
  );

  // no item is taken while a run is going out
  a_no_load_during_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item accepted during a run");

  // a final item starts a run on the next cycle
  a_final_starts_run: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && final_record) |=> result_valid)
    else $error("final item did not start a run");

  // the run ends after the end_of_run item
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && end_of_run) |=> !result_valid)
    else $error("results continue past end of run");

  // overflow flag holds for the whole run
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !end_of_run) |=> overflowed == $past(overflowed))
    else $error("overflow flag changed within a run");

endmodule

### sv/sisu_ctrl.sv
module sisu_ctrl
  import sisu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       final_record,
  input  logic       result_stall,
  input  sisu_stat_t stat,
  output logic       item_stall,
  output logic       result_valid,
  output sisu_cmd_t  cmd
);

  sisu_state_t state;
  sisu_state_t state_next;

  // handshake decode
  always_comb begin
    item_stall   = (state != ST_LOAD);
    result_valid = (state == ST_EMIT);
    cmd.insert   = item_valid && (state == ST_LOAD);
    cmd.emit     = (state == ST_EMIT) && !result_stall;
  end

  // load records until the final one, then stream the run out
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (cmd.insert && final_record) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit && stat.last_one) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/sisu_datapath.sv
module sisu_datapath
  import sisu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sisu_cmd_t          cmd,
  input  logic [ID_W-1:0]    record_id,
  input  logic [PRICE_W-1:0] price_cents,
  output sisu_stat_t         stat,
  output logic [ID_W-1:0]    sorted_id,
  output logic [PRICE_W-1:0] sorted_price,
  output logic               end_of_run,
  output logic               overflowed
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [ID_W-1:0]    cell_id    [CAPACITY];
  logic [PRICE_W-1:0] cell_price [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CNT_W-1:0]   count;
  logic               drop;
  logic               full;

  assign full = (count == CNT_W'(CAPACITY));

  // per cell: held and strictly greater than the new key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count) && (cell_price[i] > price_cents);
    end
  end

  // insertion chain: greater records move up one cell, new one lands in the gap
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic from_below;
    logic take_new;
    if (g == 0) begin : g_head
      assign from_below = 1'b0;
    end else begin : g_body
      assign from_below = gt[g-1];
    end
    assign take_new = gt[g] || (CNT_W'(g) == count);

    always_ff @(posedge clk) begin
      if (cmd.insert && !full) begin
        if (from_below) begin
          if (g > 0) begin
            cell_id[g]    <= cell_id[(g > 0) ? g - 1 : 0];
            cell_price[g] <= cell_price[(g > 0) ? g - 1 : 0];
          end
        end else if (take_new) begin
          cell_id[g]    <= record_id;
          cell_price[g] <= price_cents;
        end
      end else if (cmd.emit) begin
        if (g < CAPACITY - 1) begin
          cell_id[g]    <= cell_id[(g < CAPACITY - 1) ? g + 1 : g];
          cell_price[g] <= cell_price[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  // fill count and dropped-record flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        drop <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (cmd.emit) begin
      count <= count - CNT_W'(1);
      if (stat.last_one) drop <= 1'b0;
    end
  end

  // head cell is the result
  assign stat.last_one = (count == CNT_W'(1));
  assign sorted_id     = cell_id[0];
  assign sorted_price  = cell_price[0];
  assign end_of_run    = stat.last_one;
  assign overflowed    = drop;

endmodule

### test/tb_stable_insertion_sorter_unit.sv
module tb_stable_insertion_sorter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sisu_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int ITEMS = 330;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  // one sorted record as it leaves the block
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic               eor;
    logic               ovf;
  } sorted_rec_t;

  // directed stimulus row, typed result only for single-record sets
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic               fin;
    logic               typed;
    sorted_rec_t        want;
  } stim_row_t;

  localparam sorted_rec_t NO_WANT = '0;
  localparam int N_ROWS = 19;

  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // single records right after reset and at the field extremes
    '{31'd0, 32'd0, 1'b1, 1'b1, '{31'd0, 32'd0, 1'b1, 1'b0}},
    '{ID_MAX, PRICE_MAX, 1'b1, 1'b1, '{ID_MAX, PRICE_MAX, 1'b1, 1'b0}},
    '{31'h2AAAAAAA, 32'h55555555, 1'b1, 1'b1, '{31'h2AAAAAAA, 32'h55555555, 1'b1, 1'b0}},
    '{31'h55555555, 32'hAAAAAAAA, 1'b1, 1'b1, '{31'h55555555, 32'hAAAAAAAA, 1'b1, 1'b0}},
    // interleaved equal prices must keep arrival order
    '{31'd1, 32'd500, 1'b0, 1'b0, NO_WANT},
    '{31'd2, 32'd100, 1'b0, 1'b0, NO_WANT},
    '{31'd3, 32'd500, 1'b0, 1'b0, NO_WANT},
    '{31'd4, 32'd100, 1'b0, 1'b0, NO_WANT},
    '{31'd5, PRICE_MAX, 1'b0, 1'b0, NO_WANT},
    '{31'd6, 32'd0, 1'b1, 1'b0, NO_WANT},
    // strictly descending arrival
    '{31'd7, 32'd30, 1'b0, 1'b0, NO_WANT},
    '{31'd8, 32'd20, 1'b0, 1'b0, NO_WANT},
    '{31'd9, 32'd10, 1'b1, 1'b0, NO_WANT},
    // all prices equal
    '{31'd10, 32'd7, 1'b0, 1'b0, NO_WANT},
    '{31'd11, 32'd7, 1'b0, 1'b0, NO_WANT},
    '{31'd12, 32'd7, 1'b0, 1'b0, NO_WANT},
    '{31'd13, 32'd7, 1'b1, 1'b0, NO_WANT},
    // already ascending, extremes swapped between id and price
    '{ID_MAX, 32'd0, 1'b0, 1'b0, NO_WANT},
    '{31'd0, PRICE_MAX, 1'b1, 1'b0, NO_WANT}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [ID_W-1:0]    record_id = '0;
  logic [PRICE_W-1:0] price_cents = '0;
  logic               final_record = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [ID_W-1:0]    sorted_id;
  logic [PRICE_W-1:0] sorted_price;
  logic               end_of_run;
  logic               overflowed;

  stable_insertion_sorter_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .record_id(record_id),
    .price_cents(price_cents),
    .final_record(final_record),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sorted_id(sorted_id),
    .sorted_price(sorted_price),
    .end_of_run(end_of_run),
    .overflowed(overflowed)
  );

  // sorted store of the predictor
  logic [ID_W-1:0]    held_id [CAPACITY];
  logic [PRICE_W-1:0] held_price [CAPACITY];
  int                 held_n = 0;
  bit                 dropped = 1'b0;

  sorted_rec_t expected_sorted[$];
  sorted_rec_t fresh_run[$];

  int errors = 0;
  int records_sent = 0;
  int cycle_count = 0;
  int idle_mode = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // stable insertion of one record, full run into fresh_run on the final one
  task automatic sort_in(input logic [ID_W-1:0] id, input logic [PRICE_W-1:0] price,
                         input logic fin);
    int pos;
    if (held_n >= CAPACITY) begin
      dropped = 1'b1;
    end else begin
      pos = held_n;
      while (pos > 0 && held_price[pos-1] > price) begin
        held_price[pos] = held_price[pos-1];
        held_id[pos] = held_id[pos-1];
        pos--;
      end
      held_price[pos] = price;
      held_id[pos] = id;
      held_n++;
    end
    if (fin) begin
      for (int k = 0; k < held_n; k++) begin
        fresh_run.push_back('{held_id[k], held_price[k], k == held_n - 1, dropped});
      end
      held_n = 0;
      dropped = 1'b0;
    end
  endtask

  // offer one item with random gaps, wait for acceptance, record expectations
  task automatic send_record(input logic [ID_W-1:0] id, input logic [PRICE_W-1:0] price,
                             input logic fin, input logic typed, input sorted_rec_t want);
    int gap_pct;
    idle_mode = (records_sent / 45) % 4;
    case (idle_mode)
      1: gap_pct = 78;
      3: gap_pct = 30;
      default: gap_pct = 0;
    endcase
    while (hold_left == 0 && $urandom_range(99) < gap_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    record_id = id;
    price_cents = price;
    final_record = fin;
    do @(posedge clk); while (item_stall);
    sort_in(id, price, fin);
    if (typed) begin
      expected_sorted.push_back(want);
    end else begin
      foreach (fresh_run[k]) expected_sorted.push_back(fresh_run[k]);
    end
    fresh_run.delete();
    records_sent++;
    @(negedge clk);
  endtask

  // one random set, mostly small prices so equal keys are common
  task automatic send_set(input int n, input bit squeeze);
    logic [31:0]        word;
    logic [PRICE_W-1:0] price;
    if (squeeze) hold_request = 1'b1;
    for (int i = 0; i < n; i++) begin
      word = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: price = PRICE_W'($urandom_range(15));
        5: price = '0;
        6: price = PRICE_MAX;
        default: price = $urandom;
      endcase
      send_record(word[ID_W-1:0], price, i == n - 1, 1'b0, NO_WANT);
    end
  endtask

  // receiver stall: random per phase, plus one long hold-off
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall = 1'b1;
    end else begin
      case (idle_mode)
        2: result_stall = $urandom_range(99) < 78;
        3: result_stall = $urandom_range(99) < 30;
        default: result_stall = 1'b0;
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    sorted_rec_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result, expected none, got id %h price %h eor %b ovf %b",
                 $time, sorted_id, sorted_price, end_of_run, overflowed);
        errors++;
      end else begin
        want = expected_sorted.pop_front();
        check_field("sorted_id", 32'(want.id), 32'(sorted_id));
        check_field("sorted_price", want.price, sorted_price);
        check_field("end_of_run", 32'(want.eor), 32'(end_of_run));
        check_field("overflowed", 32'(want.ovf), 32'(overflowed));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int set_idx;
    int set_size;
    set_idx = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      send_record(DIRECTED_ROWS[r].id, DIRECTED_ROWS[r].price, DIRECTED_ROWS[r].fin,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // random sets: full store, one dropped final record, several dropped records
    while (records_sent < ITEMS) begin
      case (set_idx)
        1: set_size = CAPACITY;
        4: set_size = CAPACITY + 1;
        7: set_size = CAPACITY + 5;
        default: set_size = ($urandom_range(3) == 0) ? 1 : $urandom_range(8, 2);
      endcase
      send_set(set_size, set_idx == 1);
      set_idx++;
    end
    item_valid = 1'b0;

    // drain
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
